// ===== rtl/core/lbc_pkg.sv =====
package lbc_pkg;

   // Window bounds after reset
   localparam int RESET_X_MIN = 200;
   localparam int RESET_Y_MIN = 200;
   localparam int RESET_X_MAX = 700;
   localparam int RESET_Y_MAX = 400;

   // Register map of the csr port
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_X_MIN = 2'd0,
      CSR_Y_MIN = 2'd1,
      CSR_X_MAX = 2'd2,
      CSR_Y_MAX = 2'd3
   } csr_index_type;

   // Per-segment flags that ride along the pipeline
   typedef struct packed {
      logic reject;   // a parallel edge lies fully outside
      logic neg_dx;   // segment runs toward smaller x
      logic neg_dy;   // segment runs toward smaller y
   } flag_type;

endpackage

// ===== rtl/core/lbc_if.sv =====
interface lbc_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lbc_rsp_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic signed [COORD_WIDTH-1:0] clip_start_x;
   logic signed [COORD_WIDTH-1:0] clip_start_y;
   logic signed [COORD_WIDTH-1:0] clip_end_x;
   logic signed [COORD_WIDTH-1:0] clip_end_y;

   modport source (output valid, accepted, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                   input ready);
   modport sink   (input valid, accepted, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                   output ready);
endinterface

// ===== rtl/core/lbc_edge.sv =====
module lbc_edge #(
   parameter int W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [W-1:0]   start_x,
   input  logic signed [W-1:0]   start_y,
   input  logic signed [W-1:0]   end_x,
   input  logic signed [W-1:0]   end_y,
   input  logic signed [W-1:0]   win_x_min,
   input  logic signed [W-1:0]   win_y_min,
   input  logic signed [W-1:0]   win_x_max,
   input  logic signed [W-1:0]   win_y_max,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [W:0]     en_x_num,
   output logic [W-1:0]          en_x_den,
   output logic signed [W:0]     ex_x_num,
   output logic [W-1:0]          ex_x_den,
   output logic signed [W:0]     en_y_num,
   output logic [W-1:0]          en_y_den,
   output logic signed [W:0]     ex_y_num,
   output logic [W-1:0]          ex_y_den,
   output logic [W-1:0]          abs_dx,
   output logic [W-1:0]          abs_dy,
   output lbc_pkg::flag_type     flags,
   output logic signed [W-1:0]   pt_x1,
   output logic signed [W-1:0]   pt_y1,
   output logic signed [W-1:0]   pt_x2,
   output logic signed [W-1:0]   pt_y2
);

   logic signed [W:0] sx1, sy1, sx2, sy2, xmn, ymn, xmx, ymx;
   logic signed [W:0] dx, dy, ndx, ndy, q_l, q_r, q_b, q_t, nq_l, nq_r, nq_b, nq_t;
   logic              a_ready, b_ready;

   logic                  a_valid_ff;
   logic signed [W:0]     a_en_x_num_ff, a_en_x_num_in, a_ex_x_num_ff, a_ex_x_num_in;
   logic signed [W:0]     a_en_y_num_ff, a_en_y_num_in, a_ex_y_num_ff, a_ex_y_num_in;
   logic [W-1:0]          a_den_x_ff, a_den_x_in, a_den_y_ff, a_den_y_in;
   logic [W-1:0]          a_abs_dx_ff, a_abs_dx_in, a_abs_dy_ff, a_abs_dy_in;
   lbc_pkg::flag_type     a_flags_ff, a_flags_in;
   logic signed [W-1:0]   a_x1_ff, a_y1_ff, a_x2_ff, a_y2_ff;

   logic                  b_valid_ff;
   logic signed [W:0]     b_en_x_num_ff, b_en_x_num_in, b_ex_x_num_ff, b_ex_x_num_in;
   logic signed [W:0]     b_en_y_num_ff, b_en_y_num_in, b_ex_y_num_ff, b_ex_y_num_in;
   logic [W-1:0]          b_en_x_den_ff, b_en_x_den_in, b_ex_x_den_ff, b_ex_x_den_in;
   logic [W-1:0]          b_en_y_den_ff, b_en_y_den_in, b_ex_y_den_ff, b_ex_y_den_in;
   logic [W-1:0]          b_abs_dx_ff, b_abs_dy_ff;
   lbc_pkg::flag_type     b_flags_ff;
   logic signed [W-1:0]   b_x1_ff, b_y1_ff, b_x2_ff, b_y2_ff;

   // Stage handshake: a stage loads when empty or when its word moves on
   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Edge distances and deltas, one bit wider than the coordinates
   always_comb begin
      sx1  = {start_x[W-1], start_x};
      sy1  = {start_y[W-1], start_y};
      sx2  = {end_x[W-1], end_x};
      sy2  = {end_y[W-1], end_y};
      xmn  = {win_x_min[W-1], win_x_min};
      ymn  = {win_y_min[W-1], win_y_min};
      xmx  = {win_x_max[W-1], win_x_max};
      ymx  = {win_y_max[W-1], win_y_max};
      dx   = sx2 - sx1;
      dy   = sy2 - sy1;
      ndx  = -dx;
      ndy  = -dy;
      q_l  = sx1 - xmn;
      q_r  = xmx - sx1;
      q_b  = sy1 - ymn;
      q_t  = ymx - sy1;
      nq_l = -q_l;
      nq_r = -q_r;
      nq_b = -q_b;
      nq_t = -q_t;

      a_abs_dx_in = dx[W] ? ndx[W-1:0] : dx[W-1:0];
      a_abs_dy_in = dy[W] ? ndy[W-1:0] : dy[W-1:0];

      a_flags_in.reject = ((dx == '0) && (q_l[W] || q_r[W])) ||
                          ((dy == '0) && (q_b[W] || q_t[W]));
      a_flags_in.neg_dx = dx[W];
      a_flags_in.neg_dy = dy[W];

      // Pick the entering and leaving edge of each axis by the direction
      if (dx == '0) begin
         a_en_x_num_in = '0;
         a_ex_x_num_in = (W+1)'(1);
         a_den_x_in    = W'(1);
      end else if (!dx[W]) begin
         a_en_x_num_in = nq_l;
         a_ex_x_num_in = q_r;
         a_den_x_in    = a_abs_dx_in;
      end else begin
         a_en_x_num_in = nq_r;
         a_ex_x_num_in = q_l;
         a_den_x_in    = a_abs_dx_in;
      end

      if (dy == '0) begin
         a_en_y_num_in = '0;
         a_ex_y_num_in = (W+1)'(1);
         a_den_y_in    = W'(1);
      end else if (!dy[W]) begin
         a_en_y_num_in = nq_b;
         a_ex_y_num_in = q_t;
         a_den_y_in    = a_abs_dy_in;
      end else begin
         a_en_y_num_in = nq_t;
         a_ex_y_num_in = q_b;
         a_den_y_in    = a_abs_dy_in;
      end
   end

   // Clamp entering ratios at zero and leaving ratios at one
   always_comb begin
      if (a_en_x_num_ff > 0) begin
         b_en_x_num_in = a_en_x_num_ff;
         b_en_x_den_in = a_den_x_ff;
      end else begin
         b_en_x_num_in = '0;
         b_en_x_den_in = W'(1);
      end
      if (a_en_y_num_ff > 0) begin
         b_en_y_num_in = a_en_y_num_ff;
         b_en_y_den_in = a_den_y_ff;
      end else begin
         b_en_y_num_in = '0;
         b_en_y_den_in = W'(1);
      end
      if (a_ex_x_num_ff < $signed({1'b0, a_den_x_ff})) begin
         b_ex_x_num_in = a_ex_x_num_ff;
         b_ex_x_den_in = a_den_x_ff;
      end else begin
         b_ex_x_num_in = (W+1)'(1);
         b_ex_x_den_in = W'(1);
      end
      if (a_ex_y_num_ff < $signed({1'b0, a_den_y_ff})) begin
         b_ex_y_num_in = a_ex_y_num_ff;
         b_ex_y_den_in = a_den_y_ff;
      end else begin
         b_ex_y_num_in = (W+1)'(1);
         b_ex_y_den_in = W'(1);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   // Load stage words
   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_en_x_num_ff <= a_en_x_num_in;
         a_ex_x_num_ff <= a_ex_x_num_in;
         a_en_y_num_ff <= a_en_y_num_in;
         a_ex_y_num_ff <= a_ex_y_num_in;
         a_den_x_ff    <= a_den_x_in;
         a_den_y_ff    <= a_den_y_in;
         a_abs_dx_ff   <= a_abs_dx_in;
         a_abs_dy_ff   <= a_abs_dy_in;
         a_flags_ff    <= a_flags_in;
         a_x1_ff       <= start_x;
         a_y1_ff       <= start_y;
         a_x2_ff       <= end_x;
         a_y2_ff       <= end_y;
      end
      if (b_ready && a_valid_ff) begin
         b_en_x_num_ff <= b_en_x_num_in;
         b_en_x_den_ff <= b_en_x_den_in;
         b_ex_x_num_ff <= b_ex_x_num_in;
         b_ex_x_den_ff <= b_ex_x_den_in;
         b_en_y_num_ff <= b_en_y_num_in;
         b_en_y_den_ff <= b_en_y_den_in;
         b_ex_y_num_ff <= b_ex_y_num_in;
         b_ex_y_den_ff <= b_ex_y_den_in;
         b_abs_dx_ff   <= a_abs_dx_ff;
         b_abs_dy_ff   <= a_abs_dy_ff;
         b_flags_ff    <= a_flags_ff;
         b_x1_ff       <= a_x1_ff;
         b_y1_ff       <= a_y1_ff;
         b_x2_ff       <= a_x2_ff;
         b_y2_ff       <= a_y2_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign en_x_num  = b_en_x_num_ff;
   assign en_x_den  = b_en_x_den_ff;
   assign ex_x_num  = b_ex_x_num_ff;
   assign ex_x_den  = b_ex_x_den_ff;
   assign en_y_num  = b_en_y_num_ff;
   assign en_y_den  = b_en_y_den_ff;
   assign ex_y_num  = b_ex_y_num_ff;
   assign ex_y_den  = b_ex_y_den_ff;
   assign abs_dx    = b_abs_dx_ff;
   assign abs_dy    = b_abs_dy_ff;
   assign flags     = b_flags_ff;
   assign pt_x1     = b_x1_ff;
   assign pt_y1     = b_y1_ff;
   assign pt_x2     = b_x2_ff;
   assign pt_y2     = b_y2_ff;

endmodule

// ===== rtl/core/lbc_param.sv =====
module lbc_param #(
   parameter int W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [W:0]             en_x_num,
   input  logic [W-1:0]                  en_x_den,
   input  logic signed [W:0]             ex_x_num,
   input  logic [W-1:0]                  ex_x_den,
   input  logic signed [W:0]             en_y_num,
   input  logic [W-1:0]                  en_y_den,
   input  logic signed [W:0]             ex_y_num,
   input  logic [W-1:0]                  ex_y_den,
   input  logic [W-1:0]                  abs_dx,
   input  logic [W-1:0]                  abs_dy,
   input  lbc_pkg::flag_type             flags,
   input  logic signed [W-1:0]           pt_x1,
   input  logic signed [W-1:0]           pt_y1,
   input  logic signed [W-1:0]           pt_x2,
   input  logic signed [W-1:0]           pt_y2,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [3:0][2*W-1:0]           dividend,
   output logic [3:0][W-1:0]             divisor,
   output logic                          ok,
   output lbc_pkg::flag_type             out_flags,
   output logic signed [W-1:0]           out_x1,
   output logic signed [W-1:0]           out_y1,
   output logic signed [W-1:0]           out_x2,
   output logic signed [W-1:0]           out_y2
);

   localparam int P = 2 * W + 1;

   logic c_ready, d_ready, e_ready, f_ready;

   // Stage C: cross products between the axes
   logic                  c_valid_ff;
   logic signed [P-1:0]   c_pe_x_ff, c_pe_y_ff, c_px_x_ff, c_px_y_ff;
   logic signed [W:0]     c_en_x_num_ff, c_ex_x_num_ff, c_en_y_num_ff, c_ex_y_num_ff;
   logic [W-1:0]          c_en_x_den_ff, c_ex_x_den_ff, c_en_y_den_ff, c_ex_y_den_ff;
   logic [W-1:0]          c_abs_dx_ff, c_abs_dy_ff;
   lbc_pkg::flag_type     c_flags_ff;
   logic signed [W-1:0]   c_x1_ff, c_y1_ff, c_x2_ff, c_y2_ff;

   // Stage D: chosen entering and leaving ratios
   logic                  d_valid_ff;
   logic signed [W:0]     d_en_num_ff, d_en_num_in, d_ex_num_ff, d_ex_num_in;
   logic [W-1:0]          d_en_den_ff, d_en_den_in, d_ex_den_ff, d_ex_den_in;
   logic [W-1:0]          d_abs_dx_ff, d_abs_dy_ff;
   lbc_pkg::flag_type     d_flags_ff;
   logic signed [W-1:0]   d_x1_ff, d_y1_ff, d_x2_ff, d_y2_ff;

   // Stage E: order products and scale numerators
   logic                  e_valid_ff;
   logic signed [P-1:0]   e_pen_ff, e_pex_ff;
   logic [3:0][2*W-1:0]   e_num_ff;
   logic [W-1:0]          e_en_den_ff, e_ex_den_ff;
   lbc_pkg::flag_type     e_flags_ff;
   logic signed [W-1:0]   e_x1_ff, e_y1_ff, e_x2_ff, e_y2_ff;

   // Stage F: accept decision
   logic                  f_valid_ff;
   logic                  f_ok_ff, f_ok_in;
   logic [3:0][2*W-1:0]   f_num_ff;
   logic [3:0][W-1:0]     f_den_ff;
   lbc_pkg::flag_type     f_flags_ff;
   logic signed [W-1:0]   f_x1_ff, f_y1_ff, f_x2_ff, f_y2_ff;

   assign f_ready  = !f_valid_ff || out_ready;
   assign e_ready  = !e_valid_ff || f_ready;
   assign d_ready  = !d_valid_ff || e_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   // Keep the larger entering and the smaller leaving ratio
   always_comb begin
      if (c_pe_y_ff > c_pe_x_ff) begin
         d_en_num_in = c_en_y_num_ff;
         d_en_den_in = c_en_y_den_ff;
      end else begin
         d_en_num_in = c_en_x_num_ff;
         d_en_den_in = c_en_x_den_ff;
      end
      if (c_px_y_ff < c_px_x_ff) begin
         d_ex_num_in = c_ex_y_num_ff;
         d_ex_den_in = c_ex_y_den_ff;
      end else begin
         d_ex_num_in = c_ex_x_num_ff;
         d_ex_den_in = c_ex_x_den_ff;
      end
   end

   // Reject when the reject flag is set or the entering ratio passes the leaving one
   assign f_ok_in = !e_flags_ff.reject && !(e_pen_ff > e_pex_ff);

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (c_ready) c_valid_ff <= in_valid;
         if (d_ready) d_valid_ff <= c_valid_ff;
         if (e_ready) e_valid_ff <= d_valid_ff;
         if (f_ready) f_valid_ff <= e_valid_ff;
      end
   end

   // Load stage words
   always_ff @(posedge clock) begin
      if (c_ready && in_valid) begin
         c_pe_x_ff     <= P'(en_x_num * $signed({1'b0, en_y_den}));
         c_pe_y_ff     <= P'(en_y_num * $signed({1'b0, en_x_den}));
         c_px_x_ff     <= P'(ex_x_num * $signed({1'b0, ex_y_den}));
         c_px_y_ff     <= P'(ex_y_num * $signed({1'b0, ex_x_den}));
         c_en_x_num_ff <= en_x_num;
         c_en_x_den_ff <= en_x_den;
         c_ex_x_num_ff <= ex_x_num;
         c_ex_x_den_ff <= ex_x_den;
         c_en_y_num_ff <= en_y_num;
         c_en_y_den_ff <= en_y_den;
         c_ex_y_num_ff <= ex_y_num;
         c_ex_y_den_ff <= ex_y_den;
         c_abs_dx_ff   <= abs_dx;
         c_abs_dy_ff   <= abs_dy;
         c_flags_ff    <= flags;
         c_x1_ff       <= pt_x1;
         c_y1_ff       <= pt_y1;
         c_x2_ff       <= pt_x2;
         c_y2_ff       <= pt_y2;
      end
      if (d_ready && c_valid_ff) begin
         d_en_num_ff <= d_en_num_in;
         d_en_den_ff <= d_en_den_in;
         d_ex_num_ff <= d_ex_num_in;
         d_ex_den_ff <= d_ex_den_in;
         d_abs_dx_ff <= c_abs_dx_ff;
         d_abs_dy_ff <= c_abs_dy_ff;
         d_flags_ff  <= c_flags_ff;
         d_x1_ff     <= c_x1_ff;
         d_y1_ff     <= c_y1_ff;
         d_x2_ff     <= c_x2_ff;
         d_y2_ff     <= c_y2_ff;
      end
      if (e_ready && d_valid_ff) begin
         e_pen_ff    <= P'(d_en_num_ff * $signed({1'b0, d_ex_den_ff}));
         e_pex_ff    <= P'(d_ex_num_ff * $signed({1'b0, d_en_den_ff}));
         // Ratios of an accepted segment lie in [0,1], so W bits of numerator suffice
         e_num_ff[0] <= d_en_num_ff[W-1:0] * d_abs_dx_ff;
         e_num_ff[1] <= d_en_num_ff[W-1:0] * d_abs_dy_ff;
         e_num_ff[2] <= d_ex_num_ff[W-1:0] * d_abs_dx_ff;
         e_num_ff[3] <= d_ex_num_ff[W-1:0] * d_abs_dy_ff;
         e_en_den_ff <= d_en_den_ff;
         e_ex_den_ff <= d_ex_den_ff;
         e_flags_ff  <= d_flags_ff;
         e_x1_ff     <= d_x1_ff;
         e_y1_ff     <= d_y1_ff;
         e_x2_ff     <= d_x2_ff;
         e_y2_ff     <= d_y2_ff;
      end
      if (f_ready && e_valid_ff) begin
         f_ok_ff     <= f_ok_in;
         f_num_ff    <= e_num_ff;
         f_den_ff[0] <= e_en_den_ff;
         f_den_ff[1] <= e_en_den_ff;
         f_den_ff[2] <= e_ex_den_ff;
         f_den_ff[3] <= e_ex_den_ff;
         f_flags_ff  <= e_flags_ff;
         f_x1_ff     <= e_x1_ff;
         f_y1_ff     <= e_y1_ff;
         f_x2_ff     <= e_x2_ff;
         f_y2_ff     <= e_y2_ff;
      end
   end

   assign out_valid = f_valid_ff;
   assign dividend  = f_num_ff;
   assign divisor   = f_den_ff;
   assign ok        = f_ok_ff;
   assign out_flags = f_flags_ff;
   assign out_x1    = f_x1_ff;
   assign out_y1    = f_y1_ff;
   assign out_x2    = f_x2_ff;
   assign out_y2    = f_y2_ff;

endmodule

// ===== rtl/core/lbc_div.sv =====
module lbc_div #(
   parameter int W      = 16,
   parameter int LANES  = 4,
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [LANES-1:0][2*W-1:0]     dividend,
   input  logic [LANES-1:0][W-1:0]       divisor,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [LANES-1:0][W-1:0]       quotient,
   output logic [SIDE_W-1:0]             out_side
);

   logic [W-1:0]                  valid_ff, valid_src, stage_ready;
   logic [LANES-1:0][2*W-1:0]     acc_ff [W];
   logic [LANES-1:0][2*W-1:0]     acc_in [W];
   logic [LANES-1:0][W-1:0]       den_ff [W];
   logic [LANES-1:0][W-1:0]       den_src [W];
   logic [SIDE_W-1:0]             side_ff [W];
   logic [SIDE_W-1:0]             side_src [W];

   // One restoring step: remainder in the upper half, quotient shifts in below
   function automatic logic [2*W-1:0] div_step(input logic [2*W-1:0] acc,
                                               input logic [W-1:0]   den);
      logic [W+1:0] diff;
      diff = {1'b0, acc[2*W-1:W-1]} - {2'b00, den};
      if (!diff[W+1]) begin
         return {diff[W-1:0], acc[W-2:0], 1'b1};
      end
      return {acc[2*W-2:0], 1'b0};
   endfunction

   // Stage handshake, last stage first
   always_comb begin
      stage_ready[W-1] = !valid_ff[W-1] || out_ready;
      for (int k = W - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   // Feed of each stage
   always_comb begin
      valid_src[0] = in_valid;
      den_src[0]   = divisor;
      side_src[0]  = in_side;
      for (int l = 0; l < LANES; l++) begin
         acc_in[0][l] = div_step(dividend[l], divisor[l]);
      end
      for (int k = 1; k < W; k++) begin
         valid_src[k] = valid_ff[k-1];
         den_src[k]   = den_ff[k-1];
         side_src[k]  = side_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            acc_in[k][l] = div_step(acc_ff[k-1][l], den_ff[k-1][l]);
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < W; k++) begin
            if (stage_ready[k]) valid_ff[k] <= valid_src[k];
         end
      end
   end

   // Load stage words
   always_ff @(posedge clock) begin
      for (int k = 0; k < W; k++) begin
         if (stage_ready[k] && valid_src[k]) begin
            acc_ff[k]  <= acc_in[k];
            den_ff[k]  <= den_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quotient[l] = acc_ff[W-1][l][W-1:0];
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule

// ===== rtl/core/liang_barsky_line_clip.sv =====
// Line clipper against a rectangular window, one segment per word.
// req channel: a word carries the two endpoints of a segment (signed).
// rsp channel: a word carries the accepted flag and the clipped endpoints;
// a rejected segment comes back with its input endpoints and accepted low.
// csr port: csr_write_en writes csr_data into the window bound selected by
// csr_index (x min, y min, x max, y max). Write only while the pipeline is
// empty; there is no read-back.
// Path: a req word passes the edge stages A and B, the ratio/compare stages
// C to F, a divider stage for each quotient bit, and the output register, the
// first of which loads at the edge that takes the req word; rsp.valid rises
// when the output register loads the word.
// Throughput: one segment per cycle while the rsp side takes words; the four
// quotient lanes are fully pipelined, one bit per stage.
// Reset clears every valid bit and loads the window 200..700 by 200..400.
// When the rsp side stalls, the words stay put; empty stages still take new
// words, so req.ready drops only once every stage holds a word.
module liang_barsky_line_clip #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lbc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_data,
   lbc_req_if.sink                              req,
   lbc_rsp_if.source                            rsp
);

   localparam int W      = COORD_WIDTH;
   localparam int SIDE_W = 4 * W + 4;

   logic signed [W-1:0] win_x_min_ff, win_y_min_ff, win_x_max_ff, win_y_max_ff;

   // Edge stage outputs
   logic                  edge_valid, edge_ready;
   logic signed [W:0]     en_x_num, ex_x_num, en_y_num, ex_y_num;
   logic [W-1:0]          en_x_den, ex_x_den, en_y_den, ex_y_den, abs_dx, abs_dy;
   lbc_pkg::flag_type     edge_flags;
   logic signed [W-1:0]   edge_x1, edge_y1, edge_x2, edge_y2;

   // Ratio stage outputs
   logic                  par_valid, par_ready, par_ok;
   logic [3:0][2*W-1:0]   par_dividend;
   logic [3:0][W-1:0]     par_divisor;
   lbc_pkg::flag_type     par_flags;
   logic signed [W-1:0]   par_x1, par_y1, par_x2, par_y2;

   // Divider outputs
   logic                  div_valid, div_ready;
   logic [3:0][W-1:0]     div_quo;
   logic [SIDE_W-1:0]     div_side_in, div_side_out;
   lbc_pkg::flag_type     div_flags;
   logic                  div_ok;
   logic signed [W-1:0]   div_x1, div_y1, div_x2, div_y2;

   // Output register
   logic                  rsp_load;
   logic                  rsp_valid_ff;
   logic                  rsp_accepted_ff;
   logic signed [W-1:0]   rsp_sx_ff, rsp_sx_in, rsp_sy_ff, rsp_sy_in;
   logic signed [W-1:0]   rsp_ex_ff, rsp_ex_in, rsp_ey_ff, rsp_ey_in;

   // Window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_min_ff <= W'(lbc_pkg::RESET_X_MIN);
         win_y_min_ff <= W'(lbc_pkg::RESET_Y_MIN);
         win_x_max_ff <= W'(lbc_pkg::RESET_X_MAX);
         win_y_max_ff <= W'(lbc_pkg::RESET_Y_MAX);
      end else if (csr_write_en) begin
         case (csr_index)
            lbc_pkg::CSR_X_MIN: win_x_min_ff <= csr_data;
            lbc_pkg::CSR_Y_MIN: win_y_min_ff <= csr_data;
            lbc_pkg::CSR_X_MAX: win_x_max_ff <= csr_data;
            lbc_pkg::CSR_Y_MAX: win_y_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lbc_edge #(.W(W)) u_edge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (edge_ready),
      .start_x   (req.start_x),
      .start_y   (req.start_y),
      .end_x     (req.end_x),
      .end_y     (req.end_y),
      .win_x_min (win_x_min_ff),
      .win_y_min (win_y_min_ff),
      .win_x_max (win_x_max_ff),
      .win_y_max (win_y_max_ff),
      .out_valid (edge_valid),
      .out_ready (par_ready),
      .en_x_num  (en_x_num),
      .en_x_den  (en_x_den),
      .ex_x_num  (ex_x_num),
      .ex_x_den  (ex_x_den),
      .en_y_num  (en_y_num),
      .en_y_den  (en_y_den),
      .ex_y_num  (ex_y_num),
      .ex_y_den  (ex_y_den),
      .abs_dx    (abs_dx),
      .abs_dy    (abs_dy),
      .flags     (edge_flags),
      .pt_x1     (edge_x1),
      .pt_y1     (edge_y1),
      .pt_x2     (edge_x2),
      .pt_y2     (edge_y2)
   );

   assign req.ready = edge_ready;

   lbc_param #(.W(W)) u_param (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (edge_valid),
      .in_ready  (par_ready),
      .en_x_num  (en_x_num),
      .en_x_den  (en_x_den),
      .ex_x_num  (ex_x_num),
      .ex_x_den  (ex_x_den),
      .en_y_num  (en_y_num),
      .en_y_den  (en_y_den),
      .ex_y_num  (ex_y_num),
      .ex_y_den  (ex_y_den),
      .abs_dx    (abs_dx),
      .abs_dy    (abs_dy),
      .flags     (edge_flags),
      .pt_x1     (edge_x1),
      .pt_y1     (edge_y1),
      .pt_x2     (edge_x2),
      .pt_y2     (edge_y2),
      .out_valid (par_valid),
      .out_ready (div_ready),
      .dividend  (par_dividend),
      .divisor   (par_divisor),
      .ok        (par_ok),
      .out_flags (par_flags),
      .out_x1    (par_x1),
      .out_y1    (par_y1),
      .out_x2    (par_x2),
      .out_y2    (par_y2)
   );

   assign div_side_in = {par_ok, par_flags, par_x1, par_y1, par_x2, par_y2};

   // Output register loads when empty or when its word is taken
   assign rsp_load = !rsp_valid_ff || rsp.ready;

   lbc_div #(.W(W), .LANES(4), .SIDE_W(SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (par_valid),
      .in_ready  (div_ready),
      .dividend  (par_dividend),
      .divisor   (par_divisor),
      .in_side   (div_side_in),
      .out_valid (div_valid),
      .out_ready (rsp_load),
      .quotient  (div_quo),
      .out_side  (div_side_out)
   );

   assign {div_ok, div_flags, div_x1, div_y1, div_x2, div_y2} = div_side_out;

   // Offset the start point by the signed quotient
   function automatic logic signed [W-1:0] add_offset(input logic signed [W-1:0] base,
                                                      input logic [W-1:0]        mag,
                                                      input logic                neg);
      logic signed [W:0] off;
      logic signed [W:0] sum;
      off = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sum = $signed({base[W-1], base}) + off;
      return sum[W-1:0];
   endfunction

   always_comb begin
      if (div_ok) begin
         rsp_sx_in = add_offset(div_x1, div_quo[0], div_flags.neg_dx);
         rsp_sy_in = add_offset(div_y1, div_quo[1], div_flags.neg_dy);
         rsp_ex_in = add_offset(div_x1, div_quo[2], div_flags.neg_dx);
         rsp_ey_in = add_offset(div_y1, div_quo[3], div_flags.neg_dy);
      end else begin
         rsp_sx_in = div_x1;
         rsp_sy_in = div_y1;
         rsp_ex_in = div_x2;
         rsp_ey_in = div_y2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && div_valid) begin
         rsp_accepted_ff <= div_ok;
         rsp_sx_ff       <= rsp_sx_in;
         rsp_sy_ff       <= rsp_sy_in;
         rsp_ex_ff       <= rsp_ex_in;
         rsp_ey_ff       <= rsp_ey_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.accepted     = rsp_accepted_ff;
   assign rsp.clip_start_x = rsp_sx_ff;
   assign rsp.clip_start_y = rsp_sy_ff;
   assign rsp.clip_end_x   = rsp_ex_ff;
   assign rsp.clip_end_y   = rsp_ey_ff;

endmodule

// ===== verif/tb_liang_barsky_line_clip.sv =====
`timescale 1ns / 100ps

module tb_liang_barsky_line_clip;

   localparam int CW         = 16;
   localparam int DRAIN_WAIT = CW + 20;
   localparam int STALL_MAX  = 5000;

   typedef struct {
      logic signed [CW-1:0] sx, sy, ex, ey;
   } segment_type;

   typedef struct {
      logic                 acc;
      logic signed [CW-1:0] sx, sy, ex, ey;
   } clipped_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [lbc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CW-1:0] csr_data;

   lbc_req_if #(.COORD_WIDTH(CW)) req ();
   lbc_rsp_if #(.COORD_WIDTH(CW)) rsp ();

   liang_barsky_line_clip #(.COORD_WIDTH(CW)) u_top (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req          (req.sink),
      .rsp          (rsp.source)
   );

   segment_type          pending_segs[$];
   clipped_type          expected_clips[$];
   logic signed [CW-1:0] win_bound[4];
   int                   fail_count;
   bit                   gaps_on;
   int                   req_gap;
   int                   rsp_gap;
   int                   quiet_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Clip one segment against the mirrored window with exact rationals
   function automatic clipped_type clip_segment(segment_type s);
      longint x1 = s.sx, y1 = s.sy, x2 = s.ex, y2 = s.ey;
      longint dx = x2 - x1, dy = y2 - y1;
      longint p[4], q[4];
      longint en = 0, ed = 1, xn = 1, xd = 1;
      bit ok = 1'b1;
      clipped_type r;
      p[0] = -dx;
      p[1] = dx;
      p[2] = -dy;
      p[3] = dy;
      q[0] = x1 - longint'(win_bound[lbc_pkg::CSR_X_MIN]);
      q[1] = longint'(win_bound[lbc_pkg::CSR_X_MAX]) - x1;
      q[2] = y1 - longint'(win_bound[lbc_pkg::CSR_Y_MIN]);
      q[3] = longint'(win_bound[lbc_pkg::CSR_Y_MAX]) - y1;
      for (int i = 0; i < 4; i++) begin
         if (p[i] == 0) begin
            if (q[i] < 0) ok = 1'b0;
         end else if (p[i] < 0) begin
            // entering edge: raise t_enter to q/p
            if ((-q[i]) * ed > en * (-p[i])) begin
               en = -q[i];
               ed = -p[i];
            end
         end else begin
            // leaving edge: lower t_exit to q/p
            if (q[i] * xd < xn * p[i]) begin
               xn = q[i];
               xd = p[i];
            end
         end
      end
      if (en * xd > xn * ed) ok = 1'b0;
      if (ok) begin
         r.acc = 1'b1;
         r.sx  = CW'(x1 + (en * dx) / ed);
         r.sy  = CW'(y1 + (en * dy) / ed);
         r.ex  = CW'(x1 + (xn * dx) / xd);
         r.ey  = CW'(y1 + (xn * dy) / xd);
      end else begin
         r.acc = 1'b0;
         r.sx  = s.sx;
         r.sy  = s.sy;
         r.ex  = s.ex;
         r.ey  = s.ey;
      end
      return r;
   endfunction

   function automatic int next_gap();
      if (!gaps_on || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 4);
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("%0t: %s got %0d, want %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   // Driver: advance to the next queued word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req.valid && req.ready)
            expected_clips.insert(expected_clips.size(),
                                  clip_segment('{req.start_x, req.start_y,
                                                 req.end_x, req.end_y}));
         if (!req.valid || req.ready) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req.valid <= 1'b0;
            end else if (pending_segs.size() > 0) begin
               segment_type s;
               s = pending_segs.pop_front();
               req.start_x <= s.sx;
               req.start_y <= s.sy;
               req.end_x   <= s.ex;
               req.end_y   <= s.ey;
               req.valid   <= 1'b1;
               req_gap     <= next_gap();
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_clips.size() == 0) begin
               report_mismatch("unexpected result word", 1, 0);
            end else begin
               clipped_type w;
               w = expected_clips.pop_front();
               if (rsp.accepted !== w.acc)
                  report_mismatch("accepted", rsp.accepted, w.acc);
               if (rsp.clip_start_x !== w.sx)
                  report_mismatch("clip_start_x", rsp.clip_start_x, w.sx);
               if (rsp.clip_start_y !== w.sy)
                  report_mismatch("clip_start_y", rsp.clip_start_y, w.sy);
               if (rsp.clip_end_x !== w.ex)
                  report_mismatch("clip_end_x", rsp.clip_end_x, w.ex);
               if (rsp.clip_end_y !== w.ey)
                  report_mismatch("clip_end_y", rsp.clip_end_y, w.ey);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            rsp_gap   <= next_gap();
         end
      end
   end

   // Watchdog: drop the run if no word moves for too long
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_idle();
      while (pending_segs.size() > 0 || expected_clips.size() > 0 || req.valid)
         @(posedge clock);
   endtask

   task automatic set_window(int xlo, int ylo, int xhi, int yhi);
      int vals[4];
      vals = '{xlo, ylo, xhi, yhi};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= lbc_pkg::CSR_INDEX_WIDTH'(i);
         csr_data     <= CW'(vals[i]);
         win_bound[i] = CW'(vals[i]);
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic add_seg(int a, int b, int c, int d);
      segment_type s;
      s = '{CW'(a), CW'(b), CW'(c), CW'(d)};
      pending_segs.insert(pending_segs.size(), s);
   endtask

   // Pick a coordinate near the given bounds, clamped to the field range
   function automatic int near(int lo, int hi);
      int a, b, span, v;
      a = lo < hi ? lo : hi;
      b = lo < hi ? hi : lo;
      span = (b - a) / 2 + 8;
      v = a - span + int'($urandom_range(0, b - a + 2 * span));
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   task automatic add_random(int n);
      int x1, y1, x2, y2, kind;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 7);
         x1 = near(win_bound[lbc_pkg::CSR_X_MIN], win_bound[lbc_pkg::CSR_X_MAX]);
         y1 = near(win_bound[lbc_pkg::CSR_Y_MIN], win_bound[lbc_pkg::CSR_Y_MAX]);
         x2 = near(win_bound[lbc_pkg::CSR_X_MIN], win_bound[lbc_pkg::CSR_X_MAX]);
         y2 = near(win_bound[lbc_pkg::CSR_Y_MIN], win_bound[lbc_pkg::CSR_Y_MAX]);
         if (kind < 2) begin
            x1 = $signed(CW'($urandom));
            y1 = $signed(CW'($urandom));
            x2 = $signed(CW'($urandom));
            y2 = $signed(CW'($urandom));
         end else if (kind == 2) begin
            x2 = x1;
         end else if (kind == 3) begin
            y2 = y1;
         end else if (kind == 4 && $urandom_range(0, 3) == 0) begin
            x2 = x1;
            y2 = y1;
         end
         add_seg(x1, y1, x2, y2);
      end
   endtask

   task automatic add_directed();
      // extremes and full-range diagonals
      add_seg(-32768, -32768, 32767, 32767);
      add_seg(32767, 32767, -32768, -32768);
      add_seg(-32768, 32767, 32767, -32768);
      add_seg(32767, -32768, -32768, 32767);
      add_seg(-1, 0, 0, -1);
      // crossing the window, fully inside, fully outside
      add_seg(0, 300, 1000, 300);
      add_seg(300, 250, 600, 350);
      add_seg(0, 0, 100, 100);
      add_seg(800, 0, 100, 150);
      add_seg(100, 100, 900, 500);
      add_seg(150, 450, 750, 150);
      // parallel edges inside, on the border and outside
      add_seg(450, 100, 450, 500);
      add_seg(100, 100, 100, 500);
      add_seg(700, 500, 700, 100);
      add_seg(100, 200, 800, 200);
      add_seg(100, 401, 800, 401);
      // single points: inside, on the corner, outside
      add_seg(300, 300, 300, 300);
      add_seg(200, 400, 200, 400);
      add_seg(701, 300, 701, 300);
      add_seg(-32768, -32768, -32768, -32768);
      // touching a corner only
      add_seg(100, 300, 300, 500);
      add_seg(699, 401, 701, 399);
   endtask

   initial begin
      fail_count   = 0;
      gaps_on      = 1'b1;
      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = lbc_pkg::CSR_X_MIN;
      csr_data     = '0;
      req.valid    = 1'b0;
      req.start_x  = '0;
      req.start_y  = '0;
      req.end_x    = '0;
      req.end_y    = '0;
      rsp.ready    = 1'b0;
      win_bound[lbc_pkg::CSR_X_MIN] = CW'(lbc_pkg::RESET_X_MIN);
      win_bound[lbc_pkg::CSR_Y_MIN] = CW'(lbc_pkg::RESET_Y_MIN);
      win_bound[lbc_pkg::CSR_X_MAX] = CW'(lbc_pkg::RESET_X_MAX);
      win_bound[lbc_pkg::CSR_Y_MAX] = CW'(lbc_pkg::RESET_Y_MAX);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset window
      add_directed();
      add_random(250);
      wait_idle();

      // back-to-back stretch with no idling
      gaps_on = 1'b0;
      add_random(150);
      wait_idle();
      gaps_on = 1'b1;

      // full-range window
      set_window(-32768, -32768, 32767, 32767);
      add_directed();
      add_random(200);
      wait_idle();

      // inverted window: every segment is rejected
      set_window(500, 300, -500, -300);
      add_directed();
      add_random(150);
      wait_idle();

      // degenerate window at the extremes
      set_window(32767, -32768, 32767, -32768);
      add_random(100);
      wait_idle();

      // random windows
      for (int k = 0; k < 6; k++) begin
         set_window($signed(CW'($urandom)), $signed(CW'($urandom)),
                    $signed(CW'($urandom)), $signed(CW'($urandom)));
         add_random(70);
         wait_idle();
         set_window(-int'($urandom_range(0, 2000)), -int'($urandom_range(0, 2000)),
                    $urandom_range(0, 2000), $urandom_range(0, 2000));
         add_random(70);
         wait_idle();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
